/* rtl/core/pnghw_pkg.sv */
// ----------------------------------------------------------------------------
// pnghw_pkg: shared types and constants for the PNG chunk header walker
// Parse phases, record codes, the result record, the signature table and the color map.
// ----------------------------------------------------------------------------
`default_nettype none

package pnghw_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // Seven bytes of header tail (three fields plus CRC), counted down to one
  localparam logic [31:0] HDR_TAIL_SKIP = 32'd7;

  typedef enum logic [3:0] {
    PH_SIG,
    PH_HDR_LEN,
    PH_HDR_TYPE,
    PH_WIDTH,
    PH_HEIGHT,
    PH_DEPTH,
    PH_COLOR,
    PH_HDR_TAIL,
    PH_CH_LEN,
    PH_CH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_IDLE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_IMAGE   = 2'd0,
    KIND_CHUNK   = 2'd1,
    KIND_BAD_SIG = 2'd2,
    KIND_NO_HDR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    COLOR_GRAY       = 3'd0,
    COLOR_TRUE       = 3'd1,
    COLOR_GRAY_ALPHA = 3'd2,
    COLOR_TRUE_ALPHA = 3'd3,
    COLOR_UNKNOWN    = 3'd4
  } color_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  depth;
    logic [2:0]  color;
    logic [15:0] index;
    logic [31:0] ctype;
    logic [31:0] clen;
  } rec_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  function automatic color_e color_map(input logic [7:0] c);
    color_e m;
    unique case (c)
      8'd0:    m = COLOR_GRAY;
      8'd2:    m = COLOR_TRUE;
      8'd4:    m = COLOR_GRAY_ALPHA;
      8'd6:    m = COLOR_TRUE_ALPHA;
      default: m = COLOR_UNKNOWN;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pnghw_ifs.sv */
// ----------------------------------------------------------------------------
// pnghw_ifs: byte and record channels of the PNG chunk header walker
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnghw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface pnghw_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [7:0]  sample_depth;
  logic [2:0]  color_class;
  logic [15:0] chunk_index;
  logic [31:0] chunk_type;
  logic [31:0] chunk_length;

  modport source (output valid, output record_kind, output image_width, output image_height,
                  output sample_depth, output color_class, output chunk_index,
                  output chunk_type, output chunk_length, input ready);
  modport sink   (input valid, input record_kind, input image_width, input image_height,
                  input sample_depth, input color_class, input chunk_index,
                  input chunk_type, input chunk_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/pnghw_parser.sv */
// ----------------------------------------------------------------------------
// pnghw_parser: per-byte parse state and record generation
// Updates the parse state on each accepted byte and flags a record.
// ----------------------------------------------------------------------------
`default_nettype none

module pnghw_parser import pnghw_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       file_start_i,
  output logic            res_valid_o,
  output rec_t            res_o
);

  phase_e                 phase_q, phase_d, phase_e_w;
  logic [2:0]             pos_q, pos_d, pos_w;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_w;
  logic [31:0]            shift_q, shift_d, shift_w;
  logic [31:0]            len_q, len_d;
  logic [31:0]            skip_q, skip_d;
  logic [31:0]            width_q, width_d;
  logic [31:0]            height_q, height_d;
  logic [7:0]             depth_q, depth_d;
  logic [7:0]             color_q, color_d;
  logic                   word_done;
  logic                   emit;
  rec_t                   rec;

  always_comb begin
    // A file start restarts the parse on this very byte
    phase_e_w = file_start_i ? PH_SIG : phase_q;
    pos_w     = file_start_i ? 3'd0 : pos_q;
    cnt_w     = file_start_i ? '0 : cnt_q;
    shift_w   = {shift_q[23:0], data_byte_i};
    word_done = (pos_w >= 3'd3);

    phase_d  = phase_e_w;
    pos_d    = pos_w;
    cnt_d    = cnt_w;
    shift_d  = shift_q;
    len_d    = len_q;
    skip_d   = skip_q;
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    color_d  = color_q;
    emit     = 1'b0;
    rec      = '0;

    unique case (phase_e_w)
      PH_SIG: begin
        if (data_byte_i != sig_byte(pos_w)) begin
          phase_d  = PH_IDLE;
          emit     = 1'b1;
          rec.kind = KIND_BAD_SIG;
        end else if (pos_w >= 3'd7) begin
          pos_d   = 3'd0;
          phase_d = PH_HDR_LEN;
        end else begin
          pos_d = pos_w + 3'd1;
        end
      end
      PH_HDR_LEN, PH_HDR_TYPE, PH_WIDTH, PH_HEIGHT, PH_CH_LEN: begin
        shift_d = shift_w;
        pos_d   = word_done ? 3'd0 : pos_w + 3'd1;
        if (word_done) begin
          unique case (phase_e_w)
            PH_HDR_LEN: phase_d = PH_HDR_TYPE;
            PH_HDR_TYPE: begin
              if (shift_w != TYPE_IHDR) begin
                phase_d  = PH_IDLE;
                emit     = 1'b1;
                rec.kind = KIND_NO_HDR;
              end else begin
                phase_d = PH_WIDTH;
              end
            end
            PH_WIDTH: begin
              width_d = shift_w;
              phase_d = PH_HEIGHT;
            end
            PH_HEIGHT: begin
              height_d = shift_w;
              phase_d  = PH_DEPTH;
            end
            default: begin
              len_d   = shift_w;
              phase_d = PH_CH_TYPE;
            end
          endcase
        end
      end
      PH_DEPTH: begin
        depth_d = data_byte_i;
        phase_d = PH_COLOR;
      end
      PH_COLOR: begin
        color_d = data_byte_i;
        skip_d  = HDR_TAIL_SKIP;
        phase_d = PH_HDR_TAIL;
      end
      PH_HDR_TAIL: begin
        if (skip_q > 32'd1) begin
          skip_d = skip_q - 32'd1;
        end else begin
          skip_d     = '0;
          phase_d    = PH_CH_LEN;
          emit       = 1'b1;
          rec.kind   = KIND_IMAGE;
          rec.width  = width_q;
          rec.height = height_q;
          rec.depth  = depth_q;
          rec.color  = color_map(color_q);
        end
      end
      PH_CH_TYPE: begin
        shift_d = shift_w;
        pos_d   = word_done ? 3'd0 : pos_w + 3'd1;
        if (word_done) begin
          // Saturate the chunk count
          if (cnt_w != '1) begin
            cnt_d = cnt_w + 1'b1;
          end
          emit      = 1'b1;
          rec.kind  = KIND_CHUNK;
          rec.index = 16'(cnt_d);
          rec.ctype = shift_w;
          rec.clen  = len_q;
          if (shift_w == TYPE_IEND) begin
            phase_d = PH_IDLE;
          end else if (len_q == '0) begin
            phase_d = PH_CRC;
          end else begin
            skip_d  = len_q;
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (skip_q > 32'd1) begin
          skip_d = skip_q - 32'd1;
        end else begin
          skip_d  = '0;
          pos_d   = 3'd0;
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        if (pos_w >= 3'd3) begin
          pos_d   = 3'd0;
          phase_d = PH_CH_LEN;
        end else begin
          pos_d = pos_w + 3'd1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      pos_q   <= 3'd0;
      cnt_q   <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      shift_q  <= shift_d;
      len_q    <= len_d;
      skip_q   <= skip_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      color_q  <= color_d;
    end
  end

  assign res_valid_o = acc_i && emit;
  assign res_o       = rec;

endmodule

`default_nettype wire

/* rtl/core/pnghw_out_buf.sv */
// ----------------------------------------------------------------------------
// pnghw_out_buf: record output register with skid stage
// Holds up to two records so bytes keep flowing while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pnghw_out_buf import pnghw_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire rec_t  rec_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output rec_t       out_rec_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  rec_t out_q, out_d;
  rec_t skid_q, skid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // No push can arrive while the skid is full
      if (out_ready_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_free) begin
        out_d       = rec_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = rec_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_q;

endmodule

`default_nettype wire

/* rtl/core/png_chunk_header_walker.sv */
// ----------------------------------------------------------------------------
// png_chunk_header_walker: PNG signature, header and chunk header walker
// Takes one file byte per request and reports header and chunk records.
// ----------------------------------------------------------------------------
// A record is registered into the output register, or into the skid while rec_o stalls.
// Throughput: one byte per cycle while the skid is empty, set by the per-byte parse state update.
// A two-entry output register and skid keep bytes flowing while rec_o stalls.
// Reset (rst_ni low, asynchronous) sets the parse to expect the signature,
// clears the chunk count and empties the output stages.
`default_nettype none

module png_chunk_header_walker import pnghw_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pnghw_byte_if.sink byte_i,
  pnghw_rec_if.source rec_o
);

  logic acc;
  logic res_valid;
  logic space;
  rec_t res;
  rec_t out_rec;

  assign byte_i.ready = space;
  assign acc          = byte_i.valid && space;

  pnghw_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .data_byte_i (byte_i.data_byte),
    .file_start_i(byte_i.file_start),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pnghw_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .rec_i      (res),
    .space_o    (space),
    .out_valid_o(rec_o.valid),
    .out_ready_i(rec_o.ready),
    .out_rec_o  (out_rec)
  );

  assign rec_o.record_kind  = out_rec.kind;
  assign rec_o.image_width  = out_rec.width;
  assign rec_o.image_height = out_rec.height;
  assign rec_o.sample_depth = out_rec.depth;
  assign rec_o.color_class  = out_rec.color;
  assign rec_o.chunk_index  = out_rec.index;
  assign rec_o.chunk_type   = out_rec.ctype;
  assign rec_o.chunk_length = out_rec.clen;

endmodule

`default_nettype wire

/* rtl/core/pnghw_checker.sv */
// ----------------------------------------------------------------------------
// pnghw_checker: port-level checks for the PNG chunk header walker
// Watches the byte and record channels and flags ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pnghw_checker import pnghw_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic [7:0]  in_data_i,
  input wire logic        in_start_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_kind_i,
  input wire logic [31:0] out_type_i
);

  // Hold a stalled record
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) && $stable(out_type_i))
    else $error("record changed while stalled");

  // Byte side stalls only behind a full record side
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("byte request stalled with record slot empty");

  // Bad first byte of a file reports a bad signature next cycle
  a_bad_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_start_i && (in_data_i != 8'h89) && !out_valid_i
    |=> out_valid_i && (out_kind_i == KIND_BAD_SIG))
    else $error("bad signature not reported");

  // Good first byte of a file gives no record
  a_good_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_start_i && (in_data_i == 8'h89) && !out_valid_i
    |=> !out_valid_i)
    else $error("record on good signature byte");

endmodule

bind png_chunk_header_walker pnghw_checker u_pnghw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (byte_i.valid),
  .in_ready_i (byte_i.ready),
  .in_data_i  (byte_i.data_byte),
  .in_start_i (byte_i.file_start),
  .out_valid_i(rec_o.valid),
  .out_ready_i(rec_o.ready),
  .out_kind_i (rec_o.record_kind),
  .out_type_i (rec_o.chunk_type)
);

`default_nettype wire
